>>> src/yuvab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuvab_pkg
// Payload types, register map and BT.601 coefficients for the two-pixel
// YUV alpha blender.
// ----------------------------------------------------------------------------
package yuvab_pkg;

  typedef struct packed {
    logic [7:0] first_luma;
    logic [7:0] first_cb;
    logic [7:0] first_cr;
    logic [7:0] second_luma;
    logic [7:0] second_cb;
    logic [7:0] second_cr;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] mixed_luma;
    logic [7:0] mixed_cb;
    logic [7:0] mixed_cr;
  } mixed_pixel_t;

  typedef struct packed {
    logic signed [18:0] r;
    logic signed [18:0] g;
    logic signed [18:0] b;
  } rgb_sum_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam logic        REG_BLEND_WEIGHT = 1'b0;
  localparam logic [7:0]  BLEND_WEIGHT_RESET = 8'd1;

  // YUV to RGB
  localparam logic signed [18:0] C_Y42    = 19'sd42;
  localparam logic signed [18:0] C_R_OFS  = 19'sd24224;
  localparam logic signed [18:0] C_RV     = 19'sd153;
  localparam logic signed [18:0] C_GU     = 19'sd100;
  localparam logic signed [18:0] C_G_OFS  = 19'sd2016;
  localparam logic signed [18:0] C_GV     = 19'sd208;
  localparam logic signed [18:0] C_BU     = 19'sd4;
  localparam logic signed [18:0] C_B_OFS  = 19'sd5152;

  // RGB to YUV
  localparam logic signed [18:0] C_YR     = 19'sd66;
  localparam logic signed [18:0] C_YG     = 19'sd129;
  localparam logic signed [18:0] C_YB     = 19'sd25;
  localparam logic signed [18:0] C_Y_OFS  = 19'sd26496; // 8192 + 16384 + 1920
  localparam logic signed [18:0] C_UB     = 19'sd112;
  localparam logic signed [18:0] C_UR     = 19'sd38;
  localparam logic signed [18:0] C_UG     = 19'sd74;
  localparam logic signed [18:0] C_VR     = 19'sd112;
  localparam logic signed [18:0] C_VG     = 19'sd94;
  localparam logic signed [18:0] C_VB     = 19'sd18;
  localparam logic signed [18:0] C_ROUND  = 19'sd128;
  localparam logic [7:0]         Y_BIAS   = 8'd120;
  localparam logic [7:0]         UV_BIAS  = 8'd128;

endpackage

>>> src/yuv_two_pixel_alpha_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_two_pixel_alpha_blend
// Converts one YUV pixel of each of two images to RGB (BT.601), blends them
// by blend_weight/256 and converts the blend back to YUV.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one pixel pair enters per clock. Stages: conversion
// sums, RGB shift and clamp, blend products, blend sum, YUV sums, YUV shift
// into the output register. The whole pipeline stalls only while the output
// register holds a result that is not taken. blend_weight (APB offset 0x0,
// reset 1) is read live by the blend stage, so write it only while the
// pipeline is empty.
module yuv_two_pixel_alpha_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              src_valid,
  output logic                              src_ready,
  input  yuvab_pkg::pixel_pair_t            src_pixels,
  output logic                              blend_valid,
  input  logic                              blend_ready,
  output yuvab_pkg::mixed_pixel_t           blend_pixel,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [yuvab_pkg::PADDR_W-1:0]     paddr,
  input  logic [yuvab_pkg::PDATA_W-1:0]     pwdata,
  output logic [yuvab_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  function automatic yuvab_pkg::rgb_sum_t rgb_sums(input logic [7:0] y, input logic [7:0] u,
                                                  input logic [7:0] v);
    logic signed [18:0] ys, us, vs;
    yuvab_pkg::rgb_sum_t s;
    ys  = signed'({11'd0, y});
    us  = signed'({11'd0, u});
    vs  = signed'({11'd0, v});
    s.r = yuvab_pkg::C_Y42 * ys - yuvab_pkg::C_R_OFS + yuvab_pkg::C_RV * vs;
    s.g = yuvab_pkg::C_Y42 * ys - yuvab_pkg::C_GU * us + yuvab_pkg::C_G_OFS
          - yuvab_pkg::C_GV * vs;
    s.b = yuvab_pkg::C_Y42 * ys + yuvab_pkg::C_BU * us - yuvab_pkg::C_B_OFS;
    return s;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [12:0] x);
    logic [7:0] c;
    if (x < 13'sd0) begin
      c = 8'd0;
    end else if (x > 13'sd255) begin
      c = 8'd255;
    end else begin
      c = x[7:0];
    end
    return c;
  endfunction

  function automatic yuvab_pkg::rgb_t rgb_finish(input yuvab_pkg::rgb_sum_t s,
                                                 input logic [7:0] y, input logic [7:0] u,
                                                 input logic [7:0] v);
    logic signed [18:0] rs, gs, bs;
    logic signed [12:0] ys, us, vs;
    yuvab_pkg::rgb_t c;
    rs  = s.r >>> 8;
    gs  = s.g >>> 8;
    bs  = s.b >>> 8;
    ys  = signed'({5'd0, y});
    us  = signed'({5'd0, u});
    vs  = signed'({5'd0, v});
    c.r = clamp8(rs[12:0] + ys - 13'sd128 + vs);
    c.g = clamp8(gs[12:0] + ys + 13'sd128);
    c.b = clamp8(bs[12:0] + ys - 13'sd256 + us + us);
    return c;
  endfunction

  logic [7:0] blend_weight;
  logic       advance;
  logic       v1, v2, v3, v4, v5, v6;

  yuvab_pkg::pixel_pair_t s1_pix;
  yuvab_pkg::rgb_sum_t    s1_first, s1_second;
  yuvab_pkg::rgb_t        s2_first, s2_second;
  logic [15:0]            s3_r1, s3_g1, s3_b1;
  logic [16:0]            s3_r2, s3_g2, s3_b2;
  yuvab_pkg::rgb_t        s4_rgb;
  logic signed [18:0]     s5_y, s5_u, s5_v;
  yuvab_pkg::mixed_pixel_t s6_out;

  logic [8:0]             inv_weight;
  logic [16:0]            mix_r, mix_g, mix_b;
  logic signed [18:0]     r_ext, g_ext, b_ext;
  logic signed [18:0]     y_shift, u_shift, v_shift;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= yuvab_pkg::BLEND_WEIGHT_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == yuvab_pkg::REG_BLEND_WEIGHT) begin
      blend_weight <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == yuvab_pkg::REG_BLEND_WEIGHT) begin
      prdata = {{(yuvab_pkg::PDATA_W - 8){1'b0}}, blend_weight};
    end
  end

  // pipeline control
  assign advance     = !v6 || blend_ready;
  assign src_ready   = advance;
  assign blend_valid = v6;
  assign blend_pixel = s6_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= src_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign inv_weight = 9'd256 - {1'b0, blend_weight};
  assign mix_r      = {1'b0, s3_r1} + s3_r2 + 17'd128;
  assign mix_g      = {1'b0, s3_g1} + s3_g2 + 17'd128;
  assign mix_b      = {1'b0, s3_b1} + s3_b2 + 17'd128;
  assign r_ext      = signed'({11'd0, s4_rgb.r});
  assign g_ext      = signed'({11'd0, s4_rgb.g});
  assign b_ext      = signed'({11'd0, s4_rgb.b});
  assign y_shift    = s5_y >>> 8;
  assign u_shift    = s5_u >>> 8;
  assign v_shift    = s5_v >>> 8;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix    <= src_pixels;
      s1_first  <= rgb_sums(src_pixels.first_luma, src_pixels.first_cb, src_pixels.first_cr);
      s1_second <= rgb_sums(src_pixels.second_luma, src_pixels.second_cb,
                            src_pixels.second_cr);

      s2_first  <= rgb_finish(s1_first, s1_pix.first_luma, s1_pix.first_cb,
                              s1_pix.first_cr);
      s2_second <= rgb_finish(s1_second, s1_pix.second_luma, s1_pix.second_cb,
                              s1_pix.second_cr);

      s3_r1 <= blend_weight * s2_first.r;
      s3_g1 <= blend_weight * s2_first.g;
      s3_b1 <= blend_weight * s2_first.b;
      s3_r2 <= inv_weight * s2_second.r;
      s3_g2 <= inv_weight * s2_second.g;
      s3_b2 <= inv_weight * s2_second.b;

      s4_rgb.r <= mix_r[15:8];
      s4_rgb.g <= mix_g[15:8];
      s4_rgb.b <= mix_b[15:8];

      s5_y <= yuvab_pkg::C_YR * r_ext + yuvab_pkg::C_YG * g_ext + yuvab_pkg::C_YB * b_ext
              - yuvab_pkg::C_Y_OFS;
      s5_u <= yuvab_pkg::C_UB * b_ext - yuvab_pkg::C_UR * r_ext - yuvab_pkg::C_UG * g_ext
              + yuvab_pkg::C_ROUND;
      s5_v <= yuvab_pkg::C_VR * r_ext - yuvab_pkg::C_VG * g_ext - yuvab_pkg::C_VB * b_ext
              + yuvab_pkg::C_ROUND;

      s6_out.mixed_luma <= y_shift[7:0] + yuvab_pkg::Y_BIAS;
      s6_out.mixed_cb   <= u_shift[7:0] + yuvab_pkg::UV_BIAS;
      s6_out.mixed_cr   <= v_shift[7:0] + yuvab_pkg::UV_BIAS;
    end
  end

endmodule
